// ===== rtl/totp_pkg.sv =====
// shared types, constants and functions for the totp code block
`timescale 1ns / 1ps
package totp_pkg;

	localparam int NUM_KEY_WORDS = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CODE_W        = 20;
	localparam int STEP_W        = 64;
	localparam int WINDOW_STEPS_DEF = 1;
	localparam logic [31:0] CODE_MOD = 32'd1000000;

	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;

	// which block the datapath compresses next
	typedef enum logic [1:0] {
		BLK_IPAD,
		BLK_INNER_MSG,
		BLK_OPAD,
		BLK_OUTER_MSG
	} blk_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     load_step;  // latch step for next candidate
		logic     hash_init;  // reset chaining value to sha-1 iv
		logic     blk_load;   // load message schedule and working vars
		blk_sel_t blk;        // block to load
		logic     round_en;   // run one round
		logic     blk_fold;   // add working vars into chaining value
		logic     save_inner; // keep inner digest
		logic     trunc;      // form truncated 31-bit value
		logic     mod_start;  // start the modulo unit
		logic     record;     // record the finished code
	} totp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic round_last; // round counter at 79
		logic mod_done;   // modulo unit finished
	} totp_sts_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ===== rtl/totp_ctrl.sv =====
// controller sequencing the hmac passes for each candidate step
`timescale 1ns / 1ps
module totp_ctrl #(
	parameter int WINDOW_STEPS = totp_pkg::WINDOW_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output totp_pkg::totp_cmd_t cmd,
	input  totp_pkg::totp_sts_t sts
);
	import totp_pkg::*;

	localparam int NCAND  = 2 * WINDOW_STEPS + 1;
	localparam int CAND_W = $clog2(NCAND + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_ROUND,
		S_FOLD,
		S_MOD,
		S_WAIT,
		S_DONE
	} state_t;

	state_t          state_q;
	blk_sel_t        blk_q;
	logic [CAND_W-1:0] cand_q;
	logic            last_cand;

	assign busy      = (state_q != S_IDLE);
	assign last_cand = (cand_q == CAND_W'(NCAND - 1));
	assign done      = (state_q == S_DONE);

	// command decode
	always_comb begin
		cmd            = '0;
		cmd.blk        = blk_q;
		cmd.load_step  = (state_q == S_IDLE) && start;
		cmd.hash_init  = (state_q == S_LOAD) && (blk_q == BLK_IPAD || blk_q == BLK_OPAD);
		cmd.blk_load   = (state_q == S_LOAD);
		cmd.round_en   = (state_q == S_ROUND);
		cmd.blk_fold   = (state_q == S_FOLD);
		cmd.save_inner = (state_q == S_FOLD) && (blk_q == BLK_INNER_MSG);
		cmd.trunc      = (state_q == S_MOD);
		cmd.mod_start  = (state_q == S_MOD);
		cmd.record     = (state_q == S_WAIT) && sts.mod_done;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_q   <= BLK_IPAD;
			cand_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOAD;
						blk_q   <= BLK_IPAD;
						cand_q  <= '0;
					end
				end
				S_LOAD:  state_q <= S_ROUND;
				S_ROUND: if (sts.round_last) state_q <= S_FOLD;
				S_FOLD: begin
					if (blk_q == BLK_OUTER_MSG) begin
						state_q <= S_MOD;
					end else begin
						blk_q   <= blk_sel_t'(blk_q + 2'd1);
						state_q <= S_LOAD;
					end
				end
				S_MOD:  state_q <= S_WAIT;
				S_WAIT: begin
					if (sts.mod_done) begin
						if (last_cand) begin
							state_q <= S_DONE;
						end else begin
							cand_q  <= cand_q + 1'b1;
							blk_q   <= BLK_IPAD;
							state_q <= S_LOAD;
						end
					end
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/totp_modu.sv =====
// reduction of a 31-bit value modulo 1000000 by reciprocal multiplication
`timescale 1ns / 1ps
module totp_modu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [30:0] value,
	output logic        done,
	output logic [19:0] rem
);
	// 1000000 = 15625 * 64: reduce the upper 25 bits modulo 15625, keep the low 6 bits
	localparam logic [13:0] DIV_ODD = 14'd15625;
	// ceil(2^39 / 15625), exact quotient for any 25-bit dividend
	localparam logic [25:0] RECIP   = 26'd35184373;

	logic [24:0] hi_s1, hi_s2;
	logic [5:0]  lo_s1, lo_s2;
	logic [11:0] quo_s2;
	logic        v_s1, v_s2;
	logic        done_q;
	logic [19:0] rem_q;
	logic [50:0] prod;
	logic [24:0] back;
	logic [13:0] rem_odd;

	assign prod    = 51'(hi_s1) * 51'(RECIP);
	assign back    = 25'(quo_s2) * 25'(DIV_ODD);
	assign rem_odd = 14'(hi_s2 - back);
	assign rem     = rem_q;
	assign done    = done_q;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= go;
			v_s2   <= v_s1;
			done_q <= v_s2;
		end
	end

	// split, quotient estimate, remainder
	always_ff @(posedge clk) begin
		if (go) begin
			hi_s1 <= value[30:6];
			lo_s1 <= value[5:0];
		end
		if (v_s1) begin
			quo_s2 <= prod[50:39];
			hi_s2  <= hi_s1;
			lo_s2  <= lo_s1;
		end
		if (v_s2) rem_q <= {rem_odd, lo_s2};
	end
endmodule

// ===== rtl/totp_dp.sv =====
// datapath: key store, sha-1 round engine, truncation and code compare
`timescale 1ns / 1ps
module totp_dp #(
	parameter int WINDOW_STEPS = totp_pkg::WINDOW_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [totp_pkg::CFG_IDX_W:0] cfg_index,
	input  logic [63:0]         cfg_data,
	input  logic [63:0]         time_step,
	input  logic [19:0]         entered_code,
	input  totp_pkg::totp_cmd_t cmd,
	output totp_pkg::totp_sts_t sts,
	output logic [19:0]         current_code,
	output logic                code_matches
);
	import totp_pkg::*;

	logic [63:0]  key_q [NUM_KEY_WORDS];
	logic [63:0]  step_q;
	logic [63:0]  mid_q;
	logic [19:0]  entered_q;
	logic [31:0]  h_q [5];
	logic [159:0] inner_q;
	logic [31:0]  w_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;
	logic [6:0]   rnd_q;
	logic [30:0]  trunc_val;
	logic [19:0]  cur_q;
	logic         match_q;
	logic [19:0]  mod_rem;
	logic         mod_done;
	logic [159:0] dig;
	logic [511:0] blk;
	logic [511:0] keyblk;
	logic [31:0]  f, k, t, wn;
	logic [3:0]   off;
	logic [63:0]  first_step;

	assign first_step = time_step - 64'(WINDOW_STEPS);
	assign dig = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};

	// key register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEY_WORDS; i++) key_q[i] <= '0;
		end else if (cfg_valid && !cfg_index[CFG_IDX_W]) begin
			key_q[cfg_index[CFG_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_KEY_WORDS; i++) keyblk[511-64*i -: 64] = key_q[i];
	end

	// block selection
	always_comb begin
		unique case (cmd.blk)
			BLK_IPAD:      blk = keyblk ^ {64{8'h36}};
			BLK_OPAD:      blk = keyblk ^ {64{8'h5C}};
			BLK_INNER_MSG: blk = {step_q, 8'h80, 376'd0, 64'd576};
			BLK_OUTER_MSG: blk = {inner_q, 8'h80, 280'd0, 64'd672};
			default:       blk = '0;
		endcase
	end

	// round function
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
		end
		t  = rotl(a_q, 5) + f + e_q + k + w_q[0];
		wn = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	end

	assign sts.round_last = (rnd_q == 7'd79);
	assign sts.mod_done   = mod_done;

	// step, schedule, working vars and chaining value
	always_ff @(posedge clk) begin
		if (cmd.load_step) begin
			step_q    <= first_step;
			mid_q     <= time_step;
			entered_q <= entered_code;
		end else if (cmd.record) begin
			step_q <= step_q + 64'd1;
		end
		if (cmd.hash_init) begin
			h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
			a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
		end else if (cmd.blk_load) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end
		if (cmd.blk_load) begin
			for (int i = 0; i < 16; i++) w_q[i] <= blk[511-32*i -: 32];
			rnd_q <= '0;
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			rnd_q <= rnd_q + 7'd1;
			e_q <= d_q; d_q <= c_q; c_q <= rotl(b_q, 30); b_q <= a_q; a_q <= t;
		end
		if (cmd.blk_fold) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
		end
		if (cmd.save_inner) begin
			inner_q <= {h_q[0] + a_q, h_q[1] + b_q, h_q[2] + c_q, h_q[3] + d_q,
				h_q[4] + e_q};
		end
	end

	// dynamic truncation
	assign off = dig[3:0];
	always_comb begin
		trunc_val = 31'(dig[159 - 8*off -: 32]);
	end

	totp_modu u_modu (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.mod_start),
		.value  (trunc_val),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	// record codes and the match flag
	always_ff @(posedge clk) begin
		if (cmd.load_step) begin
			match_q <= 1'b0;
		end else if (cmd.record) begin
			if (mod_rem == entered_q) match_q <= 1'b1;
			if (step_q == mid_q) cur_q <= mod_rem;
		end
	end

	assign current_code = cur_q;
	assign code_matches = match_q;
endmodule

// ===== rtl/totp_code_generator_verifier.sv =====
// top level of the totp code generator and verifier
//
// channel   direction  handshake               payload
// command   in         start, busy             time_step, entered_code
// result    out        result_valid (1 cycle)  current_code, code_matches
// config    in         cfg_valid, cfg_ready    cfg_index, cfg_data
//
// each candidate step runs 4 sha-1 compressions on one shared
// round engine, then starts the 3-stage modulo unit and waits for it to finish.
// the strobe is registered from the controller's done state and busy drops with
// it, so a new item is taken only once the last one has finished.
// reset clears the key words and the controller; no memory clearing pass.
// the result strobe lasts one cycle and cannot be held off.
`timescale 1ns / 1ps
module totp_code_generator_verifier #(
	parameter int WINDOW_STEPS = totp_pkg::WINDOW_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] time_step,
	input  logic [19:0] entered_code,
	output logic        result_valid,
	output logic [19:0] current_code,
	output logic        code_matches,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [totp_pkg::CFG_IDX_W:0] cfg_index,
	input  logic [63:0] cfg_data
);
	import totp_pkg::*;

	totp_cmd_t cmd;
	totp_sts_t sts;
	logic      done;
	logic      rv_q;

	assign cfg_ready = 1'b1;

	totp_ctrl #(.WINDOW_STEPS(WINDOW_STEPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd),
		.sts       (sts)
	);

	totp_dp #(.WINDOW_STEPS(WINDOW_STEPS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.time_step    (time_step),
		.entered_code (entered_code),
		.cmd          (cmd),
		.sts          (sts),
		.current_code (current_code),
		.code_matches (code_matches)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_q <= 1'b0;
		else rv_q <= done;
	end
	assign result_valid = rv_q;

	// a result only follows a busy period
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without item");

	// strobe lasts one cycle
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe held");

	// idle block with no start stays idle
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !busy) else $error("spurious busy");
endmodule
